// ===== rtl/core/kamrb_pkg.sv =====
// Shared types and constants of the key-frame aligned multi-reader buffer.
// No dependencies.
package kamrb_pkg;

  localparam int DEPTH       = 64;
  localparam int NUM_READERS = 4;
  localparam int MAX_STREAMS = 8;
  localparam int AW          = $clog2(DEPTH);
  localparam int PW          = AW + 1;
  localparam int RW          = 2;
  localparam logic [PW-1:0] SKIP_LAG = PW'(5);

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_ENDED      = 3'd1;
  localparam logic [2:0] ST_BAD_STREAM = 3'd2;
  localparam logic [2:0] ST_NO_TABLE   = 3'd3;
  localparam logic [2:0] ST_EMPTY      = 3'd4;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_CAP    = 3'd1;
  localparam logic [2:0] REG_STREAMS = 3'd2;
  localparam logic [2:0] REG_VMASK  = 3'd3;
  localparam logic [2:0] REG_SKIP   = 3'd4;

  typedef enum logic [1:0] {K_WRITE, K_READ, K_END, K_NOP} kind_t;

  typedef struct packed {
    logic       mode;
    logic [6:0] cap;
    logic [3:0] streams;
    logic [7:0] vmask;
    logic [3:0] skip_en;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [1:0]  reader;
    logic [2:0]  sidx;
    logic        key;
    logic        vid;
    logic [2:0]  wr_status;
    logic [31:0] payload;
    logic [7:0]  reason;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        stored;
    logic [31:0] rpay;
    logic [2:0]  rstr;
    logic [7:0]  code;
  } res_t;

endpackage

// ===== rtl/core/kamrb_front.sv =====
// Front end: accepts beats, classifies them and holds them in a 2-entry queue.
// Depends on kamrb_pkg.
module kamrb_front import kamrb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [1:0]  reader,
  input  logic [2:0]  stream_sel,
  input  logic        key_flag,
  input  logic [31:0] payload,
  input  logic [7:0]  end_reason,
  output logic        item_valid,
  output item_t       item,
  input  logic        item_pop
);

  item_t      q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  item_t      cls;
  logic [3:0] eff_streams;
  logic       do_push, do_pop;

  always_comb begin
    eff_streams = (cfg.streams > 4'(MAX_STREAMS)) ? 4'(MAX_STREAMS) : cfg.streams;
    cls.reader  = reader;
    cls.sidx    = stream_sel;
    cls.key     = key_flag;
    cls.payload = payload;
    cls.reason  = end_reason;
    cls.vid     = cfg.vmask[stream_sel];
    case (action)
      ACT_WRITE: cls.kind = K_WRITE;
      ACT_READ:  cls.kind = K_READ;
      ACT_END:   cls.kind = K_END;
      default:   cls.kind = K_NOP;
    endcase
    if (eff_streams == 4'd0) begin
      cls.wr_status = ST_NO_TABLE;
    end else if ({1'b0, stream_sel} >= eff_streams) begin
      cls.wr_status = ST_BAD_STREAM;
    end else begin
      cls.wr_status = ST_OK;
    end
  end

  assign full       = cnt_r == 2'd2;
  assign item_valid = cnt_r != 2'd0;
  assign item       = q_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = item_pop && item_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== rtl/core/kamrb_exec.sv =====
// Back end: slot memory, group state, per-reader state and the read sequencer.
// Depends on kamrb_pkg.
module kamrb_exec import kamrb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  item_valid,
  input  item_t item,
  output logic  item_pop,
  output logic  res_valid,
  output res_t  res,
  input  logic  res_take
);

  typedef enum logic [2:0] {S_IDLE, S_UPD, S_WREQ, S_WCHK, S_WEND, S_FREQ, S_FDONE} state_t;

  typedef struct packed {
    logic [31:0] handle;
    logic [2:0]  stream;
    logic        video;
  } slot_t;

  slot_t mem [DEPTH];
  slot_t rd_data_r;
  logic  mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  slot_t mem_wdata;

  state_t        state_r;
  logic [PW-1:0] wp_r, prev_r, gs_r;
  logic [31:0]   gen_r;
  logic          await_r, ended_r;
  logic [7:0]    code_r;
  logic [PW-1:0] rpos_r [NUM_READERS];
  logic [31:0]   rgen_r [NUM_READERS];
  logic          rskip_r [NUM_READERS];
  logic [RW-1:0] rd_r;
  logic          res_v_r;
  res_t          res_r;

  logic [3:0]    eff_streams;
  logic          vid_present, aud_present;
  logic [6:0]    cap;
  logic          kf, restart, place, awaiting_nxt;
  logic [PW-1:0] wpn;
  logic [PW-1:0] u_pos, u_gs;
  logic [31:0]   u_gen, gdiff;
  logic          u_skip;
  res_t          idle_res;
  logic          rd_start;

  assign res_valid = res_v_r;
  assign res       = res_r;
  assign item_pop  = (state_r == S_IDLE) && item_valid && !res_v_r;

  // Stream presence from the table.
  always_comb begin
    eff_streams = (cfg.streams > 4'(MAX_STREAMS)) ? 4'(MAX_STREAMS) : cfg.streams;
    vid_present = 1'b0;
    aud_present = 1'b0;
    for (int i = 0; i < MAX_STREAMS; i++) begin
      if (4'(i) < eff_streams) begin
        if (cfg.vmask[i]) vid_present = 1'b1;
        else              aud_present = 1'b1;
      end
    end
  end

  // Write decision.
  always_comb begin
    cap = cfg.cap;
    if (cap == 7'd0) cap = 7'd1;
    if (cap > 7'(DEPTH)) cap = 7'(DEPTH);
    kf           = item.vid && item.key;
    awaiting_nxt = await_r;
    if (cfg.mode == 1'b0) begin
      restart = kf || (wp_r >= cap);
      if (restart) awaiting_nxt = !kf;
      place = !awaiting_nxt || !item.vid;
    end else begin
      restart = wp_r >= cap;
      place   = 1'b1;
    end
    wpn = restart ? '0 : wp_r;
  end

  // Reader catch-up.
  always_comb begin
    u_pos  = rpos_r[rd_r];
    u_gen  = rgen_r[rd_r];
    u_skip = rskip_r[rd_r];
    gdiff  = gen_r - u_gen;
    if (u_gen == gen_r) begin
      u_gs = wp_r;
    end else if (gdiff > 32'd1 || !(wp_r <= u_pos && u_pos < prev_r)) begin
      u_pos  = '0;
      u_gen  = gen_r;
      u_skip = 1'b0;
      u_gs   = wp_r;
    end else begin
      u_gs = prev_r;
    end
    if (!u_skip && cfg.skip_en[rd_r] && vid_present && aud_present && u_pos != '0 &&
        ({1'b0, u_pos} + {1'b0, SKIP_LAG}) < {1'b0, u_gs}) begin
      u_skip = 1'b1;
    end
  end

  always_comb begin
    mem_we    = item_pop && item.kind == K_WRITE && !ended_r && item.wr_status == ST_OK &&
                place && wpn < PW'(DEPTH);
    mem_waddr = wpn[AW-1:0];
    mem_wdata = '{handle: item.payload, stream: item.sidx, video: item.vid};
    mem_re    = (state_r == S_WREQ || state_r == S_FREQ) &&
                rpos_r[rd_r] < gs_r && rpos_r[rd_r] < PW'(DEPTH);
    mem_raddr = rpos_r[rd_r][AW-1:0];
  end

  // Result of a beat finished in the idle state; a read with no end mark seen starts the sequencer.
  always_comb begin
    idle_res = '0;
    rd_start = 1'b0;
    case (item.kind)
      K_END: begin
        idle_res.status = ST_ENDED;
        idle_res.code   = item.reason;
      end
      K_WRITE, K_READ: begin
        if (ended_r) begin
          idle_res.status = ST_ENDED;
          idle_res.code   = code_r;
        end else if (item.kind == K_WRITE) begin
          idle_res.status = item.wr_status;
          idle_res.stored = mem_we;
        end else if ({1'b0, item.reader} >= (RW+1)'(NUM_READERS)) begin
          idle_res.status = ST_EMPTY;
        end else begin
          rd_start = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r    <= '0;
      prev_r  <= '0;
      gs_r    <= '0;
      gen_r   <= '0;
      await_r <= 1'b1;
      ended_r <= 1'b0;
      code_r  <= '0;
      rd_r    <= '0;
      res_v_r <= 1'b0;
      res_r   <= '0;
      for (int r = 0; r < NUM_READERS; r++) begin
        rpos_r[r]  <= '0;
        rgen_r[r]  <= '0;
        rskip_r[r] <= 1'b0;
      end
    end else begin
      if (res_take && res_v_r) res_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (item_pop) begin
            res_r   <= idle_res;
            // hold the result until the read finishes
            res_v_r <= !rd_start;
            rd_r    <= item.reader;
            if (item.kind == K_END) begin
              ended_r <= 1'b1;
              code_r  <= item.reason;
            end
            if (item.kind == K_WRITE && !ended_r && item.wr_status == ST_OK) begin
              if (cfg.mode == 1'b0) await_r <= awaiting_nxt;
              if (restart) begin
                prev_r <= wp_r;
                gen_r  <= gen_r + 32'd1;
              end
              wp_r <= mem_we ? wpn + PW'(1) : wpn;
            end
            if (rd_start) state_r <= S_UPD;
          end
        end
        S_UPD: begin
          rpos_r[rd_r]  <= u_pos;
          rgen_r[rd_r]  <= u_gen;
          rskip_r[rd_r] <= u_skip;
          gs_r          <= u_gs;
          state_r       <= u_skip ? S_WREQ : S_FREQ;
        end
        S_WREQ: begin
          state_r <= mem_re ? S_WCHK : S_WEND;
        end
        S_WCHK: begin
          if (rd_data_r.video) begin
            rpos_r[rd_r] <= rpos_r[rd_r] + PW'(1);
            state_r <= S_WREQ;
          end else begin
            state_r <= S_WEND;
          end
        end
        S_WEND: begin
          if (rpos_r[rd_r] == gs_r && rgen_r[rd_r] != gen_r) begin
            rpos_r[rd_r]  <= '0;
            rgen_r[rd_r]  <= gen_r;
            rskip_r[rd_r] <= 1'b0;
            gs_r <= wp_r;
          end
          state_r <= S_FREQ;
        end
        S_FREQ: begin
          if (mem_re) begin
            state_r <= S_FDONE;
          end else begin
            res_r.status <= ST_EMPTY;
            res_v_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_FDONE: begin
          rpos_r[rd_r] <= rpos_r[rd_r] + PW'(1);
          res_r.status <= ST_OK;
          res_r.rpay   <= rd_data_r.handle;
          res_r.rstr   <= rd_data_r.stream;
          res_v_r      <= 1'b1;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/keyframe_aligned_multi_reader_buffer.sv =====
// Top level of the key-frame aligned multi-reader buffer: register port,
// front queue, back end and result queue. Depends on kamrb_pkg, kamrb_front, kamrb_exec.
//
//  channel   | handshake              | beat
//  ----------+------------------------+-----------------------------------------
//  input     | push / full            | action, reader, stream, key, payload, reason
//  result    | pop / empty            | status, stored, read payload, stream, end code
//  config    | psel/penable/pwrite    | paddr 4*i, 32-bit pwdata, pready tied high
//
// Writes, end marks and other actions execute in the back end, then hand the result
// to the result queue; a read updates the reader state, steps past video slots once
// the reader skips video, then fetches one slot, all through the single slot memory
// port. Front and result queues hold 2 beats each, so input keeps flowing while a
// result waits.
// Reset is synchronous active low; it clears all control and reader state, not slots.
module keyframe_aligned_multi_reader_buffer import kamrb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_action,
  input  logic [1:0]  in_reader,
  input  logic [2:0]  in_stream,
  input  logic        in_key_flag,
  input  logic [31:0] in_payload,
  input  logic [7:0]  in_end_reason,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_status,
  output logic        out_stored,
  output logic [31:0] out_read_payload,
  output logic [2:0]  out_read_stream,
  output logic [7:0]  out_end_code
);

  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  item_t      item;
  logic       item_valid, item_pop;
  logic       res_valid, res_take;
  res_t       res;
  res_t       oq_r [2];
  logic       oq_wr_r, oq_rd_r;
  logic [1:0] oq_cnt_r;
  logic       oq_pop;

  // Register port: write on the access phase, read back any time.
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_comb begin
    case (reg_idx)
      REG_MODE:    prdata = {31'd0, cfg_r.mode};
      REG_CAP:     prdata = {25'd0, cfg_r.cap};
      REG_STREAMS: prdata = {28'd0, cfg_r.streams};
      REG_VMASK:   prdata = {24'd0, cfg_r.vmask};
      REG_SKIP:    prdata = {28'd0, cfg_r.skip_en};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{mode: 1'b0, cap: 7'd64, streams: 4'd0, vmask: 8'd0, skip_en: 4'd0};
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_MODE:    cfg_r.mode    <= pwdata[0];
        REG_CAP:     cfg_r.cap     <= pwdata[6:0];
        REG_STREAMS: cfg_r.streams <= pwdata[3:0];
        REG_VMASK:   cfg_r.vmask   <= pwdata[7:0];
        REG_SKIP:    cfg_r.skip_en <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  kamrb_front u_front (
    .clk, .rst_n, .cfg(cfg_r), .push, .full,
    .action(in_action), .reader(in_reader), .stream_sel(in_stream),
    .key_flag(in_key_flag), .payload(in_payload), .end_reason(in_end_reason),
    .item_valid, .item, .item_pop
  );

  kamrb_exec u_exec (
    .clk, .rst_n, .cfg(cfg_r), .item_valid, .item, .item_pop,
    .res_valid, .res, .res_take
  );

  // Result queue: drain the back end whenever there is room.
  assign res_take = res_valid && oq_cnt_r != 2'd2;
  assign empty    = oq_cnt_r == 2'd0;
  assign oq_pop   = pop && !empty;

  assign out_status       = oq_r[oq_rd_r].status;
  assign out_stored       = oq_r[oq_rd_r].stored;
  assign out_read_payload = oq_r[oq_rd_r].rpay;
  assign out_read_stream  = oq_r[oq_rd_r].rstr;
  assign out_end_code     = oq_r[oq_rd_r].code;

  always_ff @(posedge clk) begin
    if (res_take) oq_r[oq_wr_r] <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (res_take) oq_wr_r <= !oq_wr_r;
      if (oq_pop)   oq_rd_r <= !oq_rd_r;
      oq_cnt_r <= oq_cnt_r + 2'(res_take) - 2'(oq_pop);
    end
  end

endmodule

// ===== rtl/core/kamrb_checker.sv =====
// Port-level checks of the buffer's result channel, bound to the top level.
// Depends on kamrb_pkg and keyframe_aligned_multi_reader_buffer.
module kamrb_checker import kamrb_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic [2:0]  out_status,
  input logic        out_stored,
  input logic [31:0] out_read_payload,
  input logic [2:0]  out_read_stream,
  input logic [7:0]  out_end_code
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_stored_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_stored) |-> out_status == ST_OK)
    else $error("stored beat without ok status");

  a_code_ended: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != ST_ENDED) |-> out_end_code == 8'd0)
    else $error("end code on a beat that is not ended");

  a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != ST_OK) |-> (out_read_payload == 32'd0 && out_read_stream == 3'd0))
    else $error("read data on a failed beat");

endmodule

bind keyframe_aligned_multi_reader_buffer kamrb_checker u_kamrb_checker (
  .clk, .rst_n, .empty, .out_status, .out_stored, .out_read_payload,
  .out_read_stream, .out_end_code
);

// ===== bench/keyframe_aligned_multi_reader_buffer_tb.sv =====
// Self-checking bench for the key-frame aligned multi-reader buffer.
// It needs kamrb_pkg and the top level. It runs a directed table, then random phases,
// and checks every result beat against an in-bench model of the buffer or a pinned value.
module keyframe_aligned_multi_reader_buffer_tb;
  import kamrb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_NOP = 2'd3;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int RANDOM_PHASES   = 12;
  localparam int PHASE_ITEMS     = 144;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        push, full, empty, pop;
  logic [1:0]  in_action, in_reader;
  logic [2:0]  in_stream;
  logic        in_key_flag;
  logic [31:0] in_payload;
  logic [7:0]  in_end_reason;
  logic [2:0]  out_status;
  logic        out_stored;
  logic [31:0] out_read_payload;
  logic [2:0]  out_read_stream;
  logic [7:0]  out_end_code;

  keyframe_aligned_multi_reader_buffer u_top (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .push, .full, .in_action, .in_reader, .in_stream, .in_key_flag,
    .in_payload, .in_end_reason, .empty, .pop, .out_status, .out_stored,
    .out_read_payload, .out_read_stream, .out_end_code
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the configuration registers and of the buffer state.
  logic        mode_q;
  logic [6:0]  cap_q;
  logic [3:0]  streams_q;
  logic [7:0]  vmask_q;
  logic [3:0]  skip_q;
  logic [31:0] slot_pay [DEPTH];
  logic [2:0]  slot_sid [DEPTH];
  bit          slot_vid [DEPTH];
  int unsigned wr_pos, prev_size;
  logic [31:0] gen;
  bit          awaiting_key, is_ended;
  logic [7:0]  end_latch;
  int unsigned rd_pos [NUM_READERS];
  logic [31:0] rd_gen [NUM_READERS];
  bit          rd_skip [NUM_READERS];

  typedef struct {
    bit   on;
    res_t want;
  } pin_t;

  typedef struct {
    logic [1:0]  act;
    logic [1:0]  rdr;
    logic [2:0]  sidx;
    logic        key;
    logic [31:0] pay;
    logic [7:0]  reason;
    pin_t        pin;
  } row_t;

  res_t  expected_beats [$];
  pin_t  pinned_beats [$];
  int    errors, mismatches, items_sent, beats_seen, end_marks;
  int    cycles;
  bit    calm, hold_req;

  function automatic bit video_stream(input logic [2:0] s);
    return vmask_q[s];
  endfunction

  function automatic int unsigned usable_streams();
    return (streams_q > 4'd8) ? 8 : int'(streams_q);
  endfunction

  function automatic void restart_reader(input int r);
    rd_pos[r]  = 0;
    rd_gen[r]  = gen;
    rd_skip[r] = 1'b0;
  endfunction

  // Bring one reader up to date; return the size of the group it reads from.
  function automatic int unsigned sync_reader(input int r);
    int unsigned gsize;
    int unsigned n;
    bit has_v, has_a;
    n = usable_streams();
    has_v = 1'b0;
    has_a = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (vmask_q[i]) has_v = 1'b1;
      else has_a = 1'b1;
    end
    if (rd_gen[r] == gen) begin
      gsize = wr_pos;
    end else if ((gen - rd_gen[r]) > 32'd1 ||
                 !(wr_pos <= rd_pos[r] && rd_pos[r] < prev_size)) begin
      restart_reader(r);
      gsize = wr_pos;
    end else begin
      gsize = prev_size;
    end
    // A lagging reader with mixed streams starts skipping video.
    if (!rd_skip[r] && skip_q[r] && has_v && has_a && rd_pos[r] > 0 &&
        rd_pos[r] + 5 < gsize)
      rd_skip[r] = 1'b1;
    if (rd_skip[r]) begin
      while (rd_pos[r] < gsize && slot_vid[rd_pos[r]]) rd_pos[r]++;
      if (rd_pos[r] == gsize && rd_gen[r] != gen) begin
        restart_reader(r);
        gsize = wr_pos;
      end
    end
    return gsize;
  endfunction

  // Advance the shadow state by one accepted beat and return its result.
  function automatic res_t forecast_beat(input logic [1:0] act, input logic [1:0] rdr,
                                         input logic [2:0] sidx, input logic key,
                                         input logic [31:0] pay, input logic [7:0] reason);
    res_t r;
    int unsigned cap, gsize, p;
    bit vid, place, kf;
    r = '0;
    r.status = ST_OK;
    cap = (cap_q == 0) ? 1 : ((cap_q > DEPTH) ? DEPTH : int'(cap_q));
    if (act == ACT_END) begin
      is_ended  = 1'b1;
      end_latch = reason;
      r.status  = ST_ENDED;
    end else if (act != ACT_NOP && is_ended) begin
      r.status = ST_ENDED;
    end else if (act == ACT_WRITE) begin
      if (usable_streams() == 0) begin
        r.status = ST_NO_TABLE;
      end else if (sidx >= usable_streams()) begin
        r.status = ST_BAD_STREAM;
      end else begin
        vid   = video_stream(sidx);
        place = 1'b1;
        if (!mode_q) begin
          kf = vid && key;
          if (kf || wr_pos >= cap) begin
            awaiting_key = !kf;
            prev_size = wr_pos;
            wr_pos = 0;
            gen++;
          end
          place = !awaiting_key || !vid;
        end else if (wr_pos >= cap) begin
          prev_size = wr_pos;
          wr_pos = 0;
          gen++;
        end
        if (place && wr_pos < DEPTH) begin
          slot_pay[wr_pos] = pay;
          slot_sid[wr_pos] = sidx;
          slot_vid[wr_pos] = vid;
          wr_pos++;
          r.stored = 1'b1;
        end
      end
    end else if (act == ACT_READ) begin
      gsize = sync_reader(rdr);
      p = rd_pos[rdr];
      if (p < gsize && p < DEPTH) begin
        r.rpay = slot_pay[p];
        r.rstr = slot_sid[p];
        rd_pos[rdr] = p + 1;
      end else begin
        r.status = ST_EMPTY;
      end
    end
    if (r.status == ST_ENDED) r.code = end_latch;
    return r;
  endfunction

  // Register writes: setup, access, then release at the write edge.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MODE:    mode_q    = val[0];
      REG_CAP:     cap_q     = val[6:0];
      REG_STREAMS: streams_q = val[3:0];
      REG_VMASK:   vmask_q   = val[7:0];
      default:     skip_q    = val[3:0];
    endcase
  endtask

  // Hold input, drain every pending result, then reprogram all registers.
  task automatic reconfigure(input logic m, input logic [6:0] c, input logic [3:0] s,
                             input logic [7:0] v, input logic [3:0] k);
    push <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    reg_write(REG_MODE, {31'd0, m});
    reg_write(REG_CAP, {25'd0, c});
    reg_write(REG_STREAMS, {28'd0, s});
    reg_write(REG_VMASK, {24'd0, v});
    reg_write(REG_SKIP, {28'd0, k});
  endtask

  // Offer one beat, keep push high until it is taken.
  task automatic offer(input row_t it);
    if (!calm && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    pinned_beats.push_back(it.pin);
    push          <= 1'b1;
    in_action     <= it.act;
    in_reader     <= it.rdr;
    in_stream     <= it.sidx;
    in_key_flag   <= it.key;
    in_payload    <= it.pay;
    in_end_reason <= it.reason;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  function automatic row_t mk(input logic [1:0] a, input logic [1:0] r, input logic [2:0] s,
                              input logic k, input logic [31:0] p, input bit on = 1'b0,
                              input logic [2:0] st = ST_OK, input logic sto = 1'b0,
                              input logic [31:0] rp = '0, input logic [2:0] rs = '0);
    row_t it;
    it.act = a; it.rdr = r; it.sidx = s; it.key = k; it.pay = p;
    it.reason = 8'($urandom_range(0, 255));
    it.pin.on = on;
    it.pin.want = '{status: st, stored: sto, rpay: rp, rstr: rs, code: 8'd0};
    return it;
  endfunction

  // Predict on acceptance; compare on every popped beat.
  always @(posedge clk) begin
    res_t got, want;
    pin_t pn;
    if (rst_n && push && !full) begin
      want = forecast_beat(in_action, in_reader, in_stream, in_key_flag,
                           in_payload, in_end_reason);
      pn = pinned_beats.pop_front();
      if (pn.on) want = pn.want;
      expected_beats.push_back(want);
      if (in_action == ACT_END) end_marks++;
    end
    if (rst_n && pop && !empty) begin
      beats_seen++;
      got = '{status: out_status, stored: out_stored, rpay: out_read_payload,
              rstr: out_read_stream, code: out_end_code};
      if (expected_beats.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result beat %p", got);
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          errors++;
          if (mismatches++ < 10)
            $display("beat %0d: status %0d/%0d stored %0b/%0b pay %h/%h stream %0d/%0d code %h/%h",
                     beats_seen, want.status, got.status, want.stored, got.stored,
                     want.rpay, got.rpay, want.rstr, got.rstr, want.code, got.code);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("keyframe_aligned_multi_reader_buffer test failed");
      $finish;
    end
  end

  // Receiver: random pop bursts, one long hold-off on request.
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    row_t rows [$];
    row_t it;
    int   wr_pct;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    push = 1'b0; pop = 1'b0;
    in_action = ACT_WRITE; in_reader = '0; in_stream = '0;
    in_key_flag = 1'b0; in_payload = '0; in_end_reason = '0;
    mode_q = 1'b0; cap_q = 7'd64; streams_q = '0; vmask_q = '0; skip_q = '0;
    wr_pos = 0; prev_size = 0; gen = '0; awaiting_key = 1'b1; is_ended = 1'b0;
    end_latch = '0;
    for (int r = 0; r < NUM_READERS; r++) begin
      rd_pos[r] = 0; rd_gen[r] = '0; rd_skip[r] = 1'b0;
    end
    errors = 0; mismatches = 0; items_sent = 0; beats_seen = 0; end_marks = 0;
    cycles = 0; calm = 1'b0; hold_req = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Under reset settings there is no stream table.
    rows.push_back(mk(ACT_WRITE, 2'd0, 3'd0, 1'b1, 32'h1234_5678, 1'b1, ST_NO_TABLE));
    rows.push_back(mk(ACT_READ,  2'd0, 3'd0, 1'b0, 32'h0, 1'b1, ST_EMPTY));
    rows.push_back(mk(ACT_NOP,   2'd3, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1, ST_OK));
    // Streams 0-3 video, 4-7 audio, all readers may skip.
    rows.push_back(mk(ACT_WRITE, 2'd0, 3'd0, 1'b0, 32'hDEAD_0000, 1'b1, ST_OK, 1'b0));
    rows.push_back(mk(ACT_WRITE, 2'd0, 3'd4, 1'b0, 32'h0, 1'b1, ST_OK, 1'b1));
    rows.push_back(mk(ACT_READ,  2'd0, 3'd0, 1'b0, 32'h0, 1'b1, ST_OK, 1'b0, 32'h0, 3'd4));
    rows.push_back(mk(ACT_READ,  2'd0, 3'd0, 1'b0, 32'h0, 1'b1, ST_EMPTY));
    rows.push_back(mk(ACT_WRITE, 2'd0, 3'd0, 1'b1, 32'hFFFF_FFFF));
    rows.push_back(mk(ACT_WRITE, 2'd0, 3'd7, 1'b1, 32'h0000_0001));
    rows.push_back(mk(ACT_WRITE, 2'd0, 3'd3, 1'b0, 32'h8000_0000));
    rows.push_back(mk(ACT_WRITE, 2'd0, 3'd5, 1'b0, 32'h5555_AAAA));
    rows.push_back(mk(ACT_WRITE, 2'd0, 3'd1, 1'b0, 32'hAAAA_5555));
    for (int r = 0; r < NUM_READERS; r++)
      rows.push_back(mk(ACT_READ, 2'(r), 3'd0, 1'b0, 32'h0));
    rows.push_back(mk(ACT_WRITE, 2'd0, 3'd2, 1'b1, 32'h0F0F_F0F0));
    rows.push_back(mk(ACT_READ,  2'd1, 3'd0, 1'b0, 32'h0));
    rows.push_back(mk(ACT_READ,  2'd3, 3'd0, 1'b0, 32'h0));
    // Frame mode, one slot, three streams.
    rows.push_back(mk(ACT_WRITE, 2'd0, 3'd7, 1'b0, 32'h0, 1'b1, ST_BAD_STREAM));
    rows.push_back(mk(ACT_WRITE, 2'd0, 3'd1, 1'b0, 32'hA5A5_A5A5));
    rows.push_back(mk(ACT_WRITE, 2'd0, 3'd0, 1'b1, 32'h5A5A_5A5A));
    rows.push_back(mk(ACT_READ,  2'd2, 3'd0, 1'b0, 32'h0));
    rows.push_back(mk(ACT_READ,  2'd2, 3'd0, 1'b0, 32'h0));
    foreach (rows[i]) begin
      if (i == 3)  reconfigure(1'b0, 7'd64, 4'd8, 8'h0F, 4'hF);
      if (i == 19) reconfigure(1'b1, 7'd1, 4'd3, 8'h01, 4'h0);
      offer(rows[i]);
    end

    // Random phases: mostly writes and reads, now and then key frames.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       reconfigure(1'b0, 7'd64, 4'd8, 8'h55, 4'hF);
        1:       reconfigure(1'b1, 7'd1, 4'd2, 8'h01, 4'h0);
        2:       reconfigure(1'b0, 7'd0, 4'd15, 8'hFF, 4'h5);
        3:       reconfigure(1'b1, 7'd127, 4'd8, 8'h00, 4'hA);
        default: reconfigure(1'($urandom_range(0, 1)),
                             7'($urandom_range(1, 20) == 1 ?
                                $urandom_range(0, 127) : $urandom_range(2, 64)),
                             4'($urandom_range(0, 12) == 0 ? $urandom_range(0, 15) :
                                $urandom_range(2, 8)),
                             8'($urandom), 4'($urandom));
      endcase
      calm = (ph == 5) || (ph == RANDOM_PHASES - 1);
      // Let the receiver sit while the sender keeps offering beats.
      if (ph == 5) hold_req = 1'b1;
      wr_pct = $urandom_range(35, 70);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it = mk(ACT_READ, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                $urandom_range(0, 4) == 0, $urandom);
        if ($urandom_range(0, 99) < wr_pct) it.act = ACT_WRITE;
        if ($urandom_range(0, 29) == 0) it.act = ACT_NOP;
        // End marks only at the tail, since they stick until reset.
        if (ph == RANDOM_PHASES - 1 && n > PHASE_ITEMS - 60 && $urandom_range(0, 3) == 0)
          it.act = ACT_END;
        offer(it);
      end
    end

    push <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d beats sent over %0d register settings, %0d results checked, %0d end marks",
             items_sent, RANDOM_PHASES + 3, beats_seen, end_marks);
    $display("%0d mismatching or unexpected results", errors);
    if (errors == 0 && expected_beats.size() == 0)
      $display("keyframe_aligned_multi_reader_buffer test passed");
    else
      $display("keyframe_aligned_multi_reader_buffer test failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/kamrb_pkg.sv
rtl/core/kamrb_front.sv
rtl/core/kamrb_exec.sv
rtl/core/keyframe_aligned_multi_reader_buffer.sv
rtl/core/kamrb_checker.sv
bench/keyframe_aligned_multi_reader_buffer_tb.sv
